### hw/rtl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/sha1_pkg.sv
`timescale 1ns / 1ps
package sha1_pkg;
   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;
   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int QDEPTH = 4;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FILL, ST_LEN, ST_ROUND, ST_ADD, ST_EMIT
   } state_type;
endpackage

### hw/rtl/sha1_front.sv
`timescale 1ns / 1ps
module sha1_front import sha1_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);
   localparam int AW = $clog2(QDEPTH);
   item_type        mem [QDEPTH];
   logic [AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem[rp_ff];
   assign wp_in     = push ? wp_ff + 1'b1 : wp_ff;
   assign rp_in     = pop ? rp_ff + 1'b1 : rp_ff;
   assign cnt_in    = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wp_ff] <= in_item;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

### hw/rtl/sha1_back.sv
`timescale 1ns / 1ps
module sha1_back import sha1_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_word,
   output logic [2:0]  out_index,
   output logic        out_last
);
   state_type    st_ff, st_in;
   logic [31:0]  w_ff [16];
   logic [31:0]  h_ff [5];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [60:0]  tot_ff;
   logic [6:0]   rnd_ff;
   logic [3:0]   fw_ff;
   logic         fin_ff, len_ff;
   logic [2:0]   oi_ff;

   logic [5:0]   pos;
   logic [31:0]  wn, f, k, t, sh_byte;
   logic [63:0]  bits;
   logic         take;

   assign pos  = tot_ff[5:0];
   assign bits = {tot_ff, 3'b000};
   assign wn   = (rnd_ff < 7'd16) ? w_ff[0] :
                 {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]} << 1 |
                 {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]} >> 31;

   always_comb begin
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = K0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = K3;
      end
   end
   assign t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + wn;

   assign in_ready  = st_ff == ST_IDLE;
   assign take      = in_valid && in_ready;
   assign out_valid = st_ff == ST_EMIT;
   assign out_word  = h_ff[oi_ff];
   assign out_index = oi_ff;
   assign out_last  = oi_ff == 3'd4;
   assign sh_byte   = {24'd0, in_item.opcode ? PAD_BYTE : in_item.data_byte}
                      << (5'(3 - pos[1:0]) << 3);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (take) begin
               if (in_item.opcode == OP_FINISH) st_in = ST_FILL;
               else if (pos == 6'd63) st_in = ST_ROUND;
            end
         end
         ST_FILL: begin
            if (fw_ff == 4'd15) st_in = len_ff ? ST_LEN : ST_ROUND;
         end
         ST_LEN:   st_in = ST_ROUND;
         ST_ROUND: if (rnd_ff == 7'd79) st_in = ST_ADD;
         ST_ADD: begin
            if (!fin_ff) st_in = ST_IDLE;
            else if (!len_ff) st_in = ST_FILL;
            else st_in = ST_EMIT;
         end
         ST_EMIT:  if (out_ready && oi_ff == 3'd4) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // w_ff is a 16-entry window rotated one word per cycle during rounds; fill zeros the words after the finish word
   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: begin
            if (take) begin
               if (pos[1:0] == 2'd0) w_ff[pos[5:2]] <= sh_byte;
               else w_ff[pos[5:2]] <= w_ff[pos[5:2]] | sh_byte;
               if (in_item.opcode == OP_FINISH) fw_ff <= pos[5:2];
            end
         end
         ST_FILL: begin
            if (fw_ff != 4'd15) begin
               fw_ff <= fw_ff + 4'd1;
               w_ff[fw_ff + 4'd1] <= '0;
            end
         end
         ST_LEN: begin
            w_ff[14] <= bits[63:32];
            w_ff[15] <= bits[31:0];
         end
         ST_ROUND: begin
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= wn;
         end
         ST_ADD: begin
            // second padding block: all zeros before the length words
            if (fin_ff && !len_ff) begin
               for (int i = 0; i < 16; i++) w_ff[i] <= '0;
            end
         end
         default: ;
      endcase
      if (st_ff == ST_ROUND) begin
         a_ff <= t; b_ff <= a_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff; e_ff <= d_ff;
      end else begin
         a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
         d_ff <= h_ff[3]; e_ff <= h_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         tot_ff <= '0;
         rnd_ff <= '0;
         fin_ff <= 1'b0;
         len_ff <= 1'b0;
         oi_ff  <= '0;
         h_ff   <= '{IV0, IV1, IV2, IV3, IV4};
      end else begin
         st_ff <= st_in;
         case (st_ff)
            ST_IDLE: begin
               rnd_ff <= '0;
               if (take) begin
                  if (in_item.opcode == OP_FINISH) begin
                     fin_ff <= 1'b1;
                     len_ff <= pos < 6'd56;
                  end else begin
                     tot_ff <= tot_ff + 61'd1;
                  end
               end
            end
            ST_FILL: ;
            ST_ROUND: rnd_ff <= rnd_ff + 7'd1;
            ST_ADD: begin
               rnd_ff <= '0;
               h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
               h_ff[4] <= h_ff[4] + e_ff;
               if (fin_ff && !len_ff) begin
                  len_ff <= 1'b1;
               end
            end
            ST_EMIT: begin
               if (out_ready) begin
                  oi_ff <= oi_ff + 3'd1;
                  if (oi_ff == 3'd4) begin
                     oi_ff  <= '0;
                     fin_ff <= 1'b0;
                     len_ff <= 1'b0;
                     tot_ff <= '0;
                     h_ff   <= '{IV0, IV1, IV2, IV3, IV4};
                  end
               end
            end
            default: ;
         endcase
      end
   end
endmodule

### hw/rtl/sha1_stream_hasher_core.sv
`timescale 1ns / 1ps
// SHA-1 byte stream hasher.
// req channel: one word per message byte. tuser = opcode (0 absorb,
// 1 finish), tdata = data_byte (ignored on finish).
// rsp channel: five words after each finish; tdata = digest word (bits
// 31:0) then word index (34:32), zero fill to 40 bits; tlast on word 4.
// A small queue in front lets up to four request words wait while a block
// is compressed. Absorb takes a byte while the core is idle, and each full
// 64-byte block is compressed one round per cycle in a single round unit,
// then the chaining add. Finish takes the word, fills the rest of the block
// with zero words, writes the length words and compresses the padding
// block; a second padding block adds another fill and length write. Then
// the five digest words follow, one per cycle while rsp_tready is high.
// A stalled receiver holds the current digest word; requests queue until
// the queue is full. Synchronous reset restores the initial chaining words
// and clears the byte count and queue.
module sha1_stream_hasher_core import sha1_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tuser,  // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] digest_word, [34:32] word_index
   output logic        rsp_tlast
);
   item_type qi, qo;
   logic     qv, qr;
   logic [31:0] w;
   logic [2:0]  idx;

   assign qi.opcode    = req_tuser;
   assign qi.data_byte = req_tdata;

   sha1_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(qi),
      .out_valid(qv), .out_ready(qr), .out_item(qo)
   );

   sha1_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(qv), .in_ready(qr), .in_item(qo),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_word(w), .out_index(idx), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {5'd0, idx, w};
endmodule

### hw/rtl/sha1_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha1_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   `CHK_IMPL(a_last_idx, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tdata[34:32] == 3'd4), "tlast mismatch")
   `CHK_IMPL(a_idx_rng, clock, reset, rsp_tvalid, rsp_tdata[34:32] <= 3'd4, "index range")
   `CHK_NEXT(a_idx_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1, "index step")
   `CHK_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stall hold")
endmodule

bind sha1_stream_hasher_core sha1_checker u_chk (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);

### tb/tb_sha1_stream_hasher_core.sv
`timescale 1ns / 1ps
module tb_sha1_stream_hasher_core;
   import sha1_pkg::*;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = OP_ABSORB;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   sha1_stream_hasher_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow hasher state
   logic [31:0] chain_h[5];
   logic [31:0] blk_w[16];
   logic [60:0] msg_bytes;

   item_type        pending_words[$];
   digest_beat_type digest_queue[$];
   int mismatches = 0;
   int digests_seen = 0;
   int words_sent = 0;
   int finishes_sent = 0;
   bit stim_done = 0;
   bit hold_rsp = 0;
   bit req_taken = 0;

   function automatic logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void hash_block();
      logic [31:0] a, b, c, d, e, f, k, t;
      a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
      for (int i = 0; i < 80; i++) begin
         if (i >= 16)
            blk_w[i % 16] = rol(blk_w[(i - 3) % 16] ^ blk_w[(i - 8) % 16] ^
                                blk_w[(i - 14) % 16] ^ blk_w[i % 16], 1);
         if (i < 20) begin
            f = (b & c) | (~b & d); k = K0;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = K1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = K2;
         end else begin
            f = b ^ c ^ d; k = K3;
         end
         t = rol(a, 5) + f + e + k + blk_w[i % 16];
         e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
   endfunction

   function automatic void clear_chain();
      chain_h[0] = IV0; chain_h[1] = IV1; chain_h[2] = IV2;
      chain_h[3] = IV3; chain_h[4] = IV4;
      msg_bytes = '0;
   endfunction

   function automatic void place_byte(int pos, logic [7:0] v);
      int sh;
      sh = (3 - pos % 4) * 8;
      if (pos % 4 == 0) blk_w[pos / 4] = 32'(v) << sh;
      else blk_w[pos / 4] |= 32'(v) << sh;
   endfunction

   function automatic void predict_word(item_type it);
      int pos;
      logic [63:0] bitlen;
      digest_beat_type beat;
      pos = int'(msg_bytes[5:0]);
      if (it.opcode == OP_ABSORB) begin
         place_byte(pos, it.data_byte);
         msg_bytes = msg_bytes + 61'd1;
         if (pos == 63) hash_block();
         return;
      end
      place_byte(pos, PAD_BYTE);
      if (pos % 4 != 3) blk_w[pos / 4] &= ~((32'd1 << ((3 - pos % 4) * 8)) - 1);
      for (int i = pos / 4 + 1; i < 16; i++) blk_w[i] = '0;
      if (pos >= 56) begin
         hash_block();
         for (int i = 0; i < 16; i++) blk_w[i] = '0;
      end
      bitlen = {msg_bytes, 3'b000};
      blk_w[14] = bitlen[63:32];
      blk_w[15] = bitlen[31:0];
      hash_block();
      for (int i = 0; i < 5; i++) begin
         beat.digest_word = chain_h[i];
         beat.word_index = 3'(i);
         beat.last_word = (i == 4);
         digest_queue.push_back(beat);
      end
      clear_chain();
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request acceptance, sampled at the rising edge
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         predict_word(item_type'({req_tuser, req_tdata}));
         words_sent++;
         if (req_tuser == OP_FINISH) finishes_sent++;
         req_taken = 1'b1;
      end
   end

   // driver
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               item_type it;
               it = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= it.opcode;
               req_tdata <= it.data_byte;
               send_gap <= gap_len();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver ready, with one long hold-off
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_rsp) rsp_tready <= 1'b0;
         else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap <= (gap_len() > 0 && $urandom_range(0, 2) == 0) ? gap_len() : 0;
         end
      end
   end

   // long receiver hold-off while a digest is pending
   initial begin
      wait (finishes_sent >= 3);
      @(posedge clock);
      while (!rsp_tvalid) @(posedge clock);
      hold_rsp = 1;
      repeat (300) @(posedge clock);
      hold_rsp = 0;
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         digest_beat_type want;
         if (digest_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected digest word %h", rsp_tdata);
         end else begin
            want = digest_queue.pop_front();
            digests_seen++;
            if (rsp_tdata[31:0] !== want.digest_word || rsp_tdata[34:32] !== want.word_index ||
                rsp_tlast !== want.last_word) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("digest mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                           want.digest_word, want.word_index, want.last_word,
                           rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
            end
         end
      end
   end

   task automatic add_msg(int len, bit mode);
      item_type it;
      for (int i = 0; i < len; i++) begin
         it.opcode = OP_ABSORB;
         case (mode)
            1'b0: it.data_byte = 8'($urandom_range(0, 255));
            default: it.data_byte = (i % 2) ? 8'hFF : 8'h00;
         endcase
         pending_words.push_back(it);
      end
      it.opcode = OP_FINISH;
      it.data_byte = 8'($urandom_range(0, 255));
      pending_words.push_back(it);
   endtask

   initial begin
      int lens[5];
      clear_chain();
      for (int i = 0; i < 16; i++) blk_w[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      // empty message, short, padding boundary lengths
      lens = '{0, 3, 55, 56, 64};
      foreach (lens[i]) add_msg(lens[i], i == 1);
      while (words_sent < 360 || pending_words.size() > 0) begin
         if (pending_words.size() == 0) begin
            case ($urandom_range(0, 3))
               0: add_msg($urandom_range(0, 8), 0);
               1: add_msg($urandom_range(50, 70), 0);
               2: add_msg($urandom_range(120, 130), 0);
               default: add_msg($urandom_range(0, 63), 0);
            endcase
         end
         @(posedge clock);
      end
      while (req_tvalid || digest_queue.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Hashed %0d messages from %0d request words, %0d digest words checked",
               finishes_sent, words_sent, digests_seen);
      if (mismatches == 0 && digest_queue.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end
endmodule
